### src/spi_master_fifo_controller_defines.svh
// Assertion macros for the SPI master FIFO controller.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef SPI_MASTER_FIFO_CONTROLLER_DEFINES_SVH
`define SPI_MASTER_FIFO_CONTROLLER_DEFINES_SVH

`ifndef SYNTHESIS
// Clocked assertion, switched off while reset is held.
`define SMFC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked assertion that also holds during reset.
`define SMFC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SMFC_ASSERT(lbl, clk, rst_n, prop, msg)
`define SMFC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

### src/smfc_pkg.sv
// Shared constants and types of the SPI master FIFO controller.
// No dependencies; used by smfc_ram and spi_master_fifo_controller.
package smfc_pkg;

    localparam int BYTE_W = 8;
    localparam int ADDR_W = 12;
    localparam int LEN_W  = 4;
    localparam int DATA_W = 32;

    localparam int DEF_TX_DEPTH = 16;
    localparam int DEF_RX_DEPTH = 16;

    // Register window offsets
    localparam logic [ADDR_W-1:0] REG_CTRL   = 12'h000;
    localparam logic [ADDR_W-1:0] REG_ENABLE = 12'h008;
    localparam logic [ADDR_W-1:0] REG_SELECT = 12'h010;
    localparam logic [ADDR_W-1:0] REG_BAUD   = 12'h014;
    localparam logic [ADDR_W-1:0] REG_STATUS = 12'h028;
    localparam logic [ADDR_W-1:0] REG_MASK   = 12'h02c;
    localparam logic [ADDR_W-1:0] REG_DATA   = 12'h060;

    localparam logic [LEN_W-1:0] LEN_BYTE = 4'd1;
    localparam logic [LEN_W-1:0] LEN_WORD = 4'd4;

    localparam logic [DATA_W-1:0] CTRL_ALLOWED   = 32'h7;
    localparam logic [DATA_W-1:0] SELECT_ALLOWED = 32'h1;
    localparam logic [DATA_W-1:0] ENABLE_OFF     = 32'h0;
    localparam logic [DATA_W-1:0] ENABLE_ON      = 32'h1;
    localparam logic [DATA_W-1:0] MASK_ALLOWED   = 32'h0;

    localparam logic ACT_READ  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    // Status byte bit positions
    localparam int ST_BUSY        = 0;
    localparam int ST_TX_NOT_FULL = 1;
    localparam int ST_TX_EMPTY    = 2;
    localparam int ST_RX_NOT_EMPTY = 3;

    typedef enum logic [1:0] {
        SEL_NONE    = 2'd0,
        SEL_ASSERT  = 2'd1,
        SEL_RELEASE = 2'd2
    } t_sel_event;

endpackage

### src/smfc_ram.sv
// Simple dual-port byte RAM with a registered read port.
// Depends on smfc_pkg for the byte width.
module smfc_ram #(
    parameter int DEPTH = smfc_pkg::DEF_TX_DEPTH,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_waddr,
    input  logic [smfc_pkg::BYTE_W-1:0] i_wdata,
    input  logic                        i_re,
    input  logic [AW-1:0]               i_raddr,
    output logic [smfc_pkg::BYTE_W-1:0] o_rdata
);
    import smfc_pkg::*;

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/spi_master_fifo_controller.sv
// Top level of the SPI master FIFO controller: access sequencer, pointers and flags.
// Depends on smfc_pkg, smfc_ram and spi_master_fifo_controller_defines.svh.

// Register front end of an SPI master with TX and RX byte FIFOs held in two
// synchronous RAMs. In the cycle a bus access is accepted, both RAMs are read
// at their head pointers; in the execute state, once the output register is
// free, the access is decoded, pointers and flags are updated, at most one RAM
// entry is written and the result register is loaded. A new access is not
// accepted until the previous one has executed, and a result waiting in the
// output register does not block the next accept; a stalled output only
// delays the execute step. FIFOs are tracked by fill counts, so there is no
// clearing pass after reset or on disable.
`include "spi_master_fifo_controller_defines.svh"

module spi_master_fifo_controller #(
    parameter int TX_DEPTH = smfc_pkg::DEF_TX_DEPTH,
    parameter int RX_DEPTH = smfc_pkg::DEF_RX_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_action,
    input  logic [smfc_pkg::ADDR_W-1:0] i_address,
    input  logic [smfc_pkg::LEN_W-1:0]  i_access_length,
    input  logic [smfc_pkg::DATA_W-1:0] i_write_data,
    input  logic [smfc_pkg::BYTE_W-1:0] i_flash_reply,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_accepted,
    output logic [smfc_pkg::BYTE_W-1:0] o_read_byte,
    output logic [1:0]                  o_select_event,
    output logic                        o_shift_valid,
    output logic [smfc_pkg::BYTE_W-1:0] o_shift_byte
);
    import smfc_pkg::*;

    localparam int TX_AW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
    localparam int TX_LW = $clog2(TX_DEPTH + 1);
    localparam int RX_AW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
    localparam int RX_LW = $clog2(RX_DEPTH + 1);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state, n_state;

    // Captured access
    logic              r_action;
    logic [ADDR_W-1:0] r_addr;
    logic [LEN_W-1:0]  r_len;
    logic [DATA_W-1:0] r_wdata;
    logic [BYTE_W-1:0] r_reply;

    // FIFO pointers and flags
    logic [TX_AW-1:0] r_tx_head, n_tx_head;
    logic [TX_LW-1:0] r_tx_level, n_tx_level;
    logic [RX_AW-1:0] r_rx_head, n_rx_head;
    logic [RX_LW-1:0] r_rx_level, n_rx_level;
    logic r_enabled, n_enabled;
    logic r_selected, n_selected;
    logic r_open, n_open;
    logic r_idle_poll, n_idle_poll;

    // Result register
    logic              r_ovalid, n_ovalid;
    logic              r_ok, n_ok;
    logic [BYTE_W-1:0] r_rbyte, n_rbyte;
    t_sel_event        r_sel_ev, n_sel_ev;
    logic              r_sv, n_sv;
    logic [BYTE_W-1:0] r_sb, n_sb;

    logic in_acc, out_free, exec;
    logic [TX_LW:0] tx_sum;
    logic [RX_LW:0] rx_sum;
    logic [TX_AW-1:0] tx_tail, tx_head_inc;
    logic [RX_AW-1:0] rx_tail, rx_head_inc;
    logic tx_we, rx_we;
    logic [BYTE_W-1:0] tx_rdata, rx_rdata;

    assign in_acc   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_ovalid || !i_out_stall;
    assign exec     = (r_state == S_EXEC) && out_free;

    // Tail = head + level, wrapped once
    always_comb begin
        tx_sum = (TX_LW + 1)'(r_tx_head) + (TX_LW + 1)'(r_tx_level);
        if (tx_sum >= (TX_LW + 1)'(TX_DEPTH)) begin
            tx_tail = TX_AW'(tx_sum - (TX_LW + 1)'(TX_DEPTH));
        end else begin
            tx_tail = TX_AW'(tx_sum);
        end
        rx_sum = (RX_LW + 1)'(r_rx_head) + (RX_LW + 1)'(r_rx_level);
        if (rx_sum >= (RX_LW + 1)'(RX_DEPTH)) begin
            rx_tail = RX_AW'(rx_sum - (RX_LW + 1)'(RX_DEPTH));
        end else begin
            rx_tail = RX_AW'(rx_sum);
        end
        tx_head_inc = (r_tx_head == TX_AW'(TX_DEPTH - 1)) ? '0 : r_tx_head + TX_AW'(1);
        rx_head_inc = (r_rx_head == RX_AW'(RX_DEPTH - 1)) ? '0 : r_rx_head + RX_AW'(1);
    end

    always_comb begin
        n_state     = r_state;
        n_tx_head   = r_tx_head;
        n_tx_level  = r_tx_level;
        n_rx_head   = r_rx_head;
        n_rx_level  = r_rx_level;
        n_enabled   = r_enabled;
        n_selected  = r_selected;
        n_open      = r_open;
        n_idle_poll = r_idle_poll;
        n_ovalid    = r_ovalid && i_out_stall;
        n_ok        = 1'b0;
        n_rbyte     = '0;
        n_sel_ev    = SEL_NONE;
        n_sv        = 1'b0;
        n_sb        = '0;
        tx_we       = 1'b0;
        rx_we       = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (exec) begin
                    n_state  = S_IDLE;
                    n_ovalid = 1'b1;
                    if (r_action == ACT_READ) begin
                        if (r_len == LEN_BYTE && r_addr == REG_STATUS) begin
                            n_ok = 1'b1;
                            if (r_enabled) begin
                                if (r_tx_level != '0) begin
                                    // Hold the transfer while RX is full
                                    if (r_rx_level != RX_LW'(RX_DEPTH)) begin
                                        n_sb        = tx_rdata;
                                        n_sv        = 1'b1;
                                        n_tx_head   = tx_head_inc;
                                        n_tx_level  = r_tx_level - TX_LW'(1);
                                        rx_we       = 1'b1;
                                        n_rx_level  = r_rx_level + RX_LW'(1);
                                        n_idle_poll = 1'b0;
                                    end
                                end else if (r_open) begin
                                    if (r_idle_poll) begin
                                        n_sel_ev    = SEL_RELEASE;
                                        n_open      = 1'b0;
                                        n_idle_poll = 1'b0;
                                    end else begin
                                        n_idle_poll = 1'b1;
                                    end
                                end
                            end
                            n_rbyte[ST_BUSY]         = n_open;
                            n_rbyte[ST_TX_NOT_FULL]  = (n_tx_level != TX_LW'(TX_DEPTH));
                            n_rbyte[ST_TX_EMPTY]     = (n_tx_level == '0);
                            n_rbyte[ST_RX_NOT_EMPTY] = (n_rx_level != '0);
                        end else if (r_len == LEN_BYTE && r_addr == REG_DATA
                                     && r_rx_level != '0) begin
                            n_ok        = 1'b1;
                            n_rbyte     = rx_rdata;
                            n_rx_head   = rx_head_inc;
                            n_rx_level  = r_rx_level - RX_LW'(1);
                            n_idle_poll = 1'b0;
                        end
                    end else if (r_addr == REG_DATA) begin
                        if (r_len == LEN_BYTE && r_enabled && r_selected
                            && r_tx_level != TX_LW'(TX_DEPTH)) begin
                            n_ok = 1'b1;
                            if (!r_open) begin
                                n_open   = 1'b1;
                                n_sel_ev = SEL_ASSERT;
                            end
                            tx_we       = 1'b1;
                            n_tx_level  = r_tx_level + TX_LW'(1);
                            n_idle_poll = 1'b0;
                        end
                    end else if (r_len == LEN_WORD) begin
                        if (r_addr == REG_ENABLE) begin
                            if (r_wdata == ENABLE_OFF) begin
                                // Drop select and empty both FIFOs
                                n_ok        = 1'b1;
                                if (r_open) begin
                                    n_sel_ev = SEL_RELEASE;
                                end
                                n_open      = 1'b0;
                                n_idle_poll = 1'b0;
                                n_enabled   = 1'b0;
                                n_tx_head   = '0;
                                n_tx_level  = '0;
                                n_rx_head   = '0;
                                n_rx_level  = '0;
                            end else if (r_wdata == ENABLE_ON) begin
                                n_ok      = 1'b1;
                                n_enabled = 1'b1;
                            end
                        end else if (!r_enabled) begin
                            if (r_addr == REG_CTRL) begin
                                n_ok = (r_wdata == CTRL_ALLOWED);
                            end else if (r_addr == REG_SELECT) begin
                                if (r_wdata == SELECT_ALLOWED) begin
                                    n_ok       = 1'b1;
                                    n_selected = 1'b1;
                                end
                            end else if (r_addr == REG_BAUD) begin
                                n_ok = (r_wdata != '0) && !r_wdata[0];
                            end else if (r_addr == REG_MASK) begin
                                n_ok = (r_wdata == MASK_ALLOWED);
                            end
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tx_head   <= '0;
            r_tx_level  <= '0;
            r_rx_head   <= '0;
            r_rx_level  <= '0;
            r_enabled   <= 1'b0;
            r_selected  <= 1'b0;
            r_open      <= 1'b0;
            r_idle_poll <= 1'b0;
            r_ovalid    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_tx_head   <= n_tx_head;
            r_tx_level  <= n_tx_level;
            r_rx_head   <= n_rx_head;
            r_rx_level  <= n_rx_level;
            r_enabled   <= n_enabled;
            r_selected  <= n_selected;
            r_open      <= n_open;
            r_idle_poll <= n_idle_poll;
            r_ovalid    <= n_ovalid;
            if (in_acc) begin
                r_action <= i_action;
                r_addr   <= i_address;
                r_len    <= i_access_length;
                r_wdata  <= i_write_data;
                r_reply  <= i_flash_reply;
            end
            if (exec) begin
                r_ok     <= n_ok;
                r_rbyte  <= n_rbyte;
                r_sel_ev <= n_sel_ev;
                r_sv     <= n_sv;
                r_sb     <= n_sb;
            end
        end
    end

    // Reads issue only on accept and writes only in the execute cycle,
    // so no access to one entry can overlap another.
    smfc_ram #(
        .DEPTH (TX_DEPTH),
        .AW    (TX_AW)
    ) u_tx_ram (
        .i_clk   (i_clk),
        .i_we    (tx_we),
        .i_waddr (tx_tail),
        .i_wdata (r_wdata[BYTE_W-1:0]),
        .i_re    (in_acc),
        .i_raddr (r_tx_head),
        .o_rdata (tx_rdata)
    );

    smfc_ram #(
        .DEPTH (RX_DEPTH),
        .AW    (RX_AW)
    ) u_rx_ram (
        .i_clk   (i_clk),
        .i_we    (rx_we),
        .i_waddr (rx_tail),
        .i_wdata (r_reply),
        .i_re    (in_acc),
        .i_raddr (r_rx_head),
        .o_rdata (rx_rdata)
    );

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_ovalid;
    assign o_accepted     = r_ok;
    assign o_read_byte    = r_rbyte;
    assign o_select_event = r_sel_ev;
    assign o_shift_valid  = r_sv;
    assign o_shift_byte   = r_sb;

    `SMFC_ASSERT(a_tx_level_bound, i_clk, i_rst_n, r_tx_level <= TX_LW'(TX_DEPTH),
                 "TX level overflow")
    `SMFC_ASSERT(a_rx_level_bound, i_clk, i_rst_n, r_rx_level <= RX_LW'(RX_DEPTH),
                 "RX level overflow")
    `SMFC_ASSERT_ALWAYS(a_no_rw_overlap, i_clk, !((tx_we || rx_we) && in_acc),
                        "RAM read and write overlap")
    `SMFC_ASSERT(a_release_closes, i_clk, i_rst_n,
                 (exec && n_sel_ev == SEL_RELEASE) |=> !r_open,
                 "release left transaction open")
    `SMFC_ASSERT(a_shift_pushes_rx, i_clk, i_rst_n,
                 (exec && n_sv) |=> (r_rx_level == $past(r_rx_level) + RX_LW'(1)),
                 "shift without RX push")

endmodule
